// ===== hdl/sdd_pkg.sv =====
// Shared types, constants and calendar functions for the signed date difference block.
// Used by sdd_date_step and signed_date_difference_days; depends on nothing.
package sdd_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int MAG_W   = 22;
    localparam int DIFF_W  = 23;
    localparam int RES_W   = 9;
    localparam int RED_K_W = 3;

    localparam logic [MAG_W-1:0]   MAG_LIMIT   = '1;
    localparam logic [RES_W-1:0]   LEAP_CYCLE  = 9'd400;
    localparam logic [RES_W-1:0]   RES_LAST    = 9'd399;
    localparam logic [RED_K_W-1:0] RED_K_FIRST = 3'd5;
    localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd12;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED_FIRST,
        ST_RED_SECOND,
        ST_CHECK,
        ST_WALK,
        ST_DONE
    } sdd_state_t;

    // A year is leap when divisible by 4, except centuries not divisible by 400.
    // res400 is the year modulo 400.
    function automatic logic is_leap(logic [YEAR_W-1:0] year, logic [RES_W-1:0] res400);
        logic century;
        century = (res400 == 9'd100) || (res400 == 9'd200) || (res400 == 9'd300);
        return (year[1:0] == 2'd0) && !century;
    endfunction

    function automatic logic [DAY_W-1:0] month_days(logic [MONTH_W-1:0] month, logic leap);
        logic [DAY_W-1:0] len;
        unique case (month)
            MONTH_FEB:                 len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic date_ok(date_t d, logic [RES_W-1:0] res400);
        logic month_ok;
        month_ok = (d.month >= 4'd1) && (d.month <= MONTH_DEC);
        return month_ok && (d.day != '0) &&
               (d.day <= month_days(d.month, is_leap(d.year, res400)));
    endfunction

endpackage

// ===== hdl/sdd_date_step.sv =====
// Calendar successor: advances a date by one day, with the year residue modulo 400.
// Depends on sdd_pkg.
module sdd_date_step (
    input  sdd_pkg::date_t          cur,
    input  logic [sdd_pkg::RES_W-1:0] cur_res,
    output sdd_pkg::date_t          nxt,
    output logic [sdd_pkg::RES_W-1:0] nxt_res
);

    logic                       leap;
    logic [sdd_pkg::DAY_W-1:0]  len;

    assign leap = sdd_pkg::is_leap(cur.year, cur_res);
    assign len  = sdd_pkg::month_days(cur.month, leap);

    always_comb
    begin
        nxt     = cur;
        nxt_res = cur_res;
        if (cur.day < len)
        begin
            nxt.day = cur.day + 5'd1;
        end
        else
        begin
            nxt.day = 5'd1;
            if (cur.month == sdd_pkg::MONTH_DEC)
            begin
                // Year rollover keeps the residue in step with the year.
                nxt.month = 4'd1;
                nxt.year  = cur.year + 14'd1;
                nxt_res   = (cur_res == sdd_pkg::RES_LAST) ? '0 : cur_res + 9'd1;
            end
            else
            begin
                nxt.month = cur.month + 4'd1;
            end
        end
    end

endmodule

// ===== hdl/signed_date_difference_days.sv =====
// Top level of the signed Gregorian date difference block.
// Depends on sdd_pkg and sdd_date_step.
//
// Accepts one beat (two dates and an include-end flag) when start is high while busy is
// low, and answers with one result beat: done is high for exactly one cycle with
// day_difference and date_invalid valid in that cycle, and the receiver cannot stall it,
// so it must capture the beat then. busy stays high through the reduction, the check, the
// walk and the done state; an item with an invalid date skips the walk. The calendar walk
// advances the earlier date by one day per cycle through a single date successor unit
// until it meets the later date. Before the walk, each year is reduced modulo 400 by one
// shared subtract-and-compare unit, which gives the leap-year test without a divider. The
// result is positive when the second date is later, and the magnitude grows by one when
// include_end is set, so equal dates give +1 then. A month outside 1 to 12 or a day
// outside its month in either date gives date_invalid high with a difference of zero.
// The magnitude saturates at 4194303.
module signed_date_difference_days (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [sdd_pkg::DAY_W-1:0]         first_day,
    input  logic [sdd_pkg::MONTH_W-1:0]       first_month,
    input  logic [sdd_pkg::YEAR_W-1:0]        first_year,
    input  logic [sdd_pkg::DAY_W-1:0]         second_day,
    input  logic [sdd_pkg::MONTH_W-1:0]       second_month,
    input  logic [sdd_pkg::YEAR_W-1:0]        second_year,
    input  logic                              include_end,
    output logic                              done,
    output logic signed [sdd_pkg::DIFF_W-1:0] day_difference,
    output logic                              date_invalid
);

    sdd_pkg::sdd_state_t state_reg, state_next;

    // Captured operands.
    sdd_pkg::date_t first_reg, first_next;
    sdd_pkg::date_t second_reg, second_next;
    logic           inc_reg, inc_next;

    // Shared modulo-400 reduction unit.
    logic [sdd_pkg::YEAR_W-1:0]  res_reg, res_next;
    logic [sdd_pkg::RED_K_W-1:0] red_k_reg, red_k_next;
    logic [sdd_pkg::RES_W-1:0]   res_first_reg, res_first_next;
    logic [sdd_pkg::RES_W-1:0]   res_second_reg, res_second_next;
    logic [sdd_pkg::YEAR_W:0]    red_sub;
    logic [sdd_pkg::YEAR_W-1:0]  red_out;

    // Walk state.
    sdd_pkg::date_t             walk_reg, walk_next;
    logic [sdd_pkg::RES_W-1:0]  walk_res_reg, walk_res_next;
    sdd_pkg::date_t             target_reg, target_next;
    logic [sdd_pkg::MAG_W-1:0]  day_counter_reg, day_counter_next;
    logic                       negate_result_reg, negate_result_next;

    // Result beat.
    logic [sdd_pkg::DIFF_W-1:0] diff_reg, diff_next;
    logic                       invalid_reg, invalid_next;

    sdd_pkg::date_t             step_date;
    logic [sdd_pkg::RES_W-1:0]  step_res;
    logic                       accept;
    logic                       red_last;
    logic                       dates_ok;
    logic                       first_later;
    logic                       walk_met;
    logic [sdd_pkg::DIFF_W-1:0] mag_ext;

    sdd_date_step u_step (
        .cur     (walk_reg),
        .cur_res (walk_res_reg),
        .nxt     (step_date),
        .nxt_res (step_res)
    );

    assign accept   = start && !busy;
    assign red_last = (red_k_reg == '0);

    // One conditional subtraction of 400 shifted left by k; six steps leave year mod 400.
    assign red_sub = {1'b0, res_reg}
                   - ({{(sdd_pkg::YEAR_W + 1 - sdd_pkg::RES_W){1'b0}}, sdd_pkg::LEAP_CYCLE}
                      << red_k_reg);
    assign red_out = red_sub[sdd_pkg::YEAR_W] ? res_reg : red_sub[sdd_pkg::YEAR_W-1:0];

    assign dates_ok    = sdd_pkg::date_ok(first_reg, res_first_reg) &&
                         sdd_pkg::date_ok(second_reg, res_second_reg);
    // For valid dates, ordering on year, month, day matches ordering on day numbers.
    assign first_later = (first_reg > second_reg);
    assign walk_met    = (walk_reg == target_reg);
    assign mag_ext     = {1'b0, day_counter_reg};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sdd_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = sdd_pkg::ST_RED_FIRST;
                end
            end
            sdd_pkg::ST_RED_FIRST:
            begin
                if (red_last)
                begin
                    state_next = sdd_pkg::ST_RED_SECOND;
                end
            end
            sdd_pkg::ST_RED_SECOND:
            begin
                if (red_last)
                begin
                    state_next = sdd_pkg::ST_CHECK;
                end
            end
            sdd_pkg::ST_CHECK:
            begin
                state_next = dates_ok ? sdd_pkg::ST_WALK : sdd_pkg::ST_DONE;
            end
            sdd_pkg::ST_WALK:
            begin
                if (walk_met)
                begin
                    state_next = sdd_pkg::ST_DONE;
                end
            end
            sdd_pkg::ST_DONE:
            begin
                state_next = sdd_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sdd_pkg::ST_IDLE;
            end
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        busy = (state_reg != sdd_pkg::ST_IDLE);
        done = (state_reg == sdd_pkg::ST_DONE);
    end

    assign day_difference = $signed(diff_reg);
    assign date_invalid   = invalid_reg;

    // Datapath.
    always_comb
    begin
        first_next         = first_reg;
        second_next        = second_reg;
        inc_next           = inc_reg;
        res_next           = res_reg;
        red_k_next         = red_k_reg;
        res_first_next     = res_first_reg;
        res_second_next    = res_second_reg;
        walk_next          = walk_reg;
        walk_res_next      = walk_res_reg;
        target_next        = target_reg;
        day_counter_next   = day_counter_reg;
        negate_result_next = negate_result_reg;
        diff_next          = diff_reg;
        invalid_next       = invalid_reg;

        unique case (state_reg)
            sdd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    first_next  = '{year: first_year, month: first_month, day: first_day};
                    second_next = '{year: second_year, month: second_month, day: second_day};
                    inc_next    = include_end;
                    res_next    = first_year;
                    red_k_next  = sdd_pkg::RED_K_FIRST;
                end
            end
            sdd_pkg::ST_RED_FIRST:
            begin
                res_next   = red_out;
                red_k_next = red_k_reg - 3'd1;
                if (red_last)
                begin
                    res_first_next = red_out[sdd_pkg::RES_W-1:0];
                    res_next       = second_reg.year;
                    red_k_next     = sdd_pkg::RED_K_FIRST;
                end
            end
            sdd_pkg::ST_RED_SECOND:
            begin
                res_next   = red_out;
                red_k_next = red_k_reg - 3'd1;
                if (red_last)
                begin
                    res_second_next = red_out[sdd_pkg::RES_W-1:0];
                end
            end
            sdd_pkg::ST_CHECK:
            begin
                if (!dates_ok)
                begin
                    // State is left untouched for a rejected item.
                    diff_next    = '0;
                    invalid_next = 1'b1;
                end
                else
                begin
                    day_counter_next   = {{(sdd_pkg::MAG_W - 1){1'b0}}, inc_reg};
                    negate_result_next = first_later;
                    if (first_later)
                    begin
                        walk_next     = second_reg;
                        walk_res_next = res_second_reg;
                        target_next   = first_reg;
                    end
                    else
                    begin
                        walk_next     = first_reg;
                        walk_res_next = res_first_reg;
                        target_next   = second_reg;
                    end
                end
            end
            sdd_pkg::ST_WALK:
            begin
                if (walk_met)
                begin
                    diff_next    = negate_result_reg ? ('0 - mag_ext) : mag_ext;
                    invalid_next = 1'b0;
                end
                else
                begin
                    walk_next     = step_date;
                    walk_res_next = step_res;
                    if (day_counter_reg != sdd_pkg::MAG_LIMIT)
                    begin
                        day_counter_next = day_counter_reg + 22'd1;
                    end
                end
            end
            sdd_pkg::ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= sdd_pkg::ST_IDLE;
            red_k_reg         <= '0;
            walk_reg          <= '{year: 14'd1, month: 4'd1, day: 5'd1};
            walk_res_reg      <= 9'd1;
            day_counter_reg   <= '0;
            negate_result_reg <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            red_k_reg         <= red_k_next;
            walk_reg          <= walk_next;
            walk_res_reg      <= walk_res_next;
            day_counter_reg   <= day_counter_next;
            negate_result_reg <= negate_result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg      <= first_next;
        second_reg     <= second_next;
        inc_reg        <= inc_next;
        res_reg        <= res_next;
        res_first_reg  <= res_first_next;
        res_second_reg <= res_second_next;
        target_reg     <= target_next;
        diff_reg       <= diff_next;
        invalid_reg    <= invalid_next;
    end

    // A rejected date always reports a zero difference.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && date_invalid |-> day_difference == '0)
        else $error("invalid result carries a nonzero difference");

    // The result strobe lasts one cycle and is followed by idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result strobe longer than one cycle");

    // An accepted beat starts the modulo reduction of the first year.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> state_reg == sdd_pkg::ST_RED_FIRST && red_k_reg == sdd_pkg::RED_K_FIRST)
        else $error("accepted beat did not start reduction");

    // The day count never goes down during the walk.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sdd_pkg::ST_WALK && $past(state_reg == sdd_pkg::ST_WALK)
        |-> day_counter_reg >= $past(day_counter_reg))
        else $error("day count decreased during walk");

endmodule

// ===== tb/sdd_difference_monitor.sv =====
`timescale 1ns / 1ps
// Monitor for the signed date difference block: predicts each result from the accepted beat.
// Compares every done beat with the oldest prediction. Depends on sdd_pkg for widths.
module sdd_difference_monitor (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic [sdd_pkg::DAY_W-1:0]         first_day,
    input  logic [sdd_pkg::MONTH_W-1:0]       first_month,
    input  logic [sdd_pkg::YEAR_W-1:0]        first_year,
    input  logic [sdd_pkg::DAY_W-1:0]         second_day,
    input  logic [sdd_pkg::MONTH_W-1:0]       second_month,
    input  logic [sdd_pkg::YEAR_W-1:0]        second_year,
    input  logic                              include_end,
    input  logic                              done,
    input  logic signed [sdd_pkg::DIFF_W-1:0] day_difference,
    input  logic                              date_invalid,
    output int                                error_count,
    output int                                outstanding
);

    typedef struct packed {
        logic signed [sdd_pkg::DIFF_W-1:0] difference;
        logic                              invalid;
    } day_span_t;

    day_span_t expected_spans[$];

    function automatic bit leap_year(int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_length(int unsigned m, int unsigned y);
        case (m)
            2:          return leap_year(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:    return 31;
        endcase
    endfunction

    function automatic bit date_is_legal(int unsigned d, int unsigned m, int unsigned y);
        if (m < 1 || m > 12)
            return 1'b0;
        return (d >= 1) && (d <= month_length(m, y));
    endfunction

    // Days elapsed since 1 January of year zero.
    function automatic int unsigned day_ordinal(int unsigned d, int unsigned m, int unsigned y);
        int unsigned total;
        int unsigned k;
        total = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
        for (k = 1; k < m; k++)
            total += month_length(k, y);
        return total + d - 1;
    endfunction

    function automatic day_span_t predict_span(
        int unsigned d1, int unsigned m1, int unsigned y1,
        int unsigned d2, int unsigned m2, int unsigned y2, bit count_end);
        day_span_t                         span;
        int unsigned                       from_day;
        int unsigned                       to_day;
        int unsigned                       magnitude;
        bit                                negative;
        logic signed [sdd_pkg::DIFF_W-1:0] value;
        span.invalid    = 1'b0;
        span.difference = '0;
        if (!date_is_legal(d1, m1, y1) || !date_is_legal(d2, m2, y2)) begin
            span.invalid = 1'b1;
            return span;
        end
        from_day = day_ordinal(d1, m1, y1);
        to_day   = day_ordinal(d2, m2, y2);
        negative = from_day > to_day;
        magnitude = negative ? from_day - to_day : to_day - from_day;
        magnitude += count_end;
        if (magnitude > sdd_pkg::MAG_LIMIT)
            magnitude = sdd_pkg::MAG_LIMIT;
        value = magnitude[sdd_pkg::DIFF_W-1:0];
        if (negative)
            value = -value;
        span.difference = value;
        return span;
    endfunction

    always @(posedge clk) begin
        day_span_t wanted;
        if (!rst_n) begin
            expected_spans.delete();
        end else begin
            if (done) begin
                if (expected_spans.size() == 0) begin
                    $error("day_difference beat with nothing outstanding: got %0d",
                           day_difference);
                    error_count++;
                end else begin
                    wanted = expected_spans.pop_front();
                    if (day_difference !== wanted.difference) begin
                        $error("day_difference mismatch: expected %0d, got %0d",
                               $signed(wanted.difference), day_difference);
                        error_count++;
                    end
                    if (date_invalid !== wanted.invalid) begin
                        $error("date_invalid mismatch: expected %0b, got %0b",
                               wanted.invalid, date_invalid);
                        error_count++;
                    end
                end
            end
            if (start && !busy)
                expected_spans.push_back(predict_span(32'(first_day), 32'(first_month),
                                                      32'(first_year), 32'(second_day),
                                                      32'(second_month), 32'(second_year),
                                                      include_end));
        end
        outstanding = expected_spans.size();
    end

endmodule

// ===== tb/signed_date_difference_days_test.sv =====
`timescale 1ns / 1ps
// Top of the signed date difference testbench: clock, reset, stimulus and the final verdict.
// Depends on sdd_pkg, signed_date_difference_days and sdd_difference_monitor.
module signed_date_difference_days_test;

    localparam int YEAR_TOP     = (1 << sdd_pkg::YEAR_W) - 1;
    localparam int RANDOM_ITEMS = 100;

    logic                              clk          = 1'b0;
    logic                              rst_n        = 1'b0;
    logic                              start        = 1'b0;
    logic                              busy;
    logic [sdd_pkg::DAY_W-1:0]         first_day    = '0;
    logic [sdd_pkg::MONTH_W-1:0]       first_month  = '0;
    logic [sdd_pkg::YEAR_W-1:0]        first_year   = '0;
    logic [sdd_pkg::DAY_W-1:0]         second_day   = '0;
    logic [sdd_pkg::MONTH_W-1:0]       second_month = '0;
    logic [sdd_pkg::YEAR_W-1:0]        second_year  = '0;
    logic                              include_end  = 1'b0;
    logic                              done;
    logic signed [sdd_pkg::DIFF_W-1:0] day_difference;
    logic                              date_invalid;

    int mismatch_total;
    int results_pending;

    // Beats left in the current burst before the sender drops start for a while.
    int burst_left = 0;

    always #5 clk = ~clk;

    signed_date_difference_days u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .first_day      (first_day),
        .first_month    (first_month),
        .first_year     (first_year),
        .second_day     (second_day),
        .second_month   (second_month),
        .second_year    (second_year),
        .include_end    (include_end),
        .done           (done),
        .day_difference (day_difference),
        .date_invalid   (date_invalid)
    );

    sdd_difference_monitor u_monitor (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .first_day      (first_day),
        .first_month    (first_month),
        .first_year     (first_year),
        .second_day     (second_day),
        .second_month   (second_month),
        .second_year    (second_year),
        .include_end    (include_end),
        .done           (done),
        .day_difference (day_difference),
        .date_invalid   (date_invalid),
        .error_count    (mismatch_total),
        .outstanding    (results_pending)
    );

    // The saturating beat alone walks about 4.2 million days, and every other beat is
    // kept to a few thousand at most, so this bound is several times the slowest
    // correct run.
    initial begin
        #250_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Drives one beat at the falling edge and holds it until the block takes it. busy
    // only moves on the rising edge, so its level at the falling edge tells whether the
    // coming rising edge accepts the beat. After that the sender may pause, so that gaps
    // land both inside a walk and on the cycles just after busy drops.
    task automatic present_dates(
        input int d1,
        input int m1,
        input int y1,
        input int d2,
        input int m2,
        input int y2,
        input int count_end);
        int gap;
        @(negedge clk);
        first_day    <= d1[sdd_pkg::DAY_W-1:0];
        first_month  <= m1[sdd_pkg::MONTH_W-1:0];
        first_year   <= y1[sdd_pkg::YEAR_W-1:0];
        second_day   <= d2[sdd_pkg::DAY_W-1:0];
        second_month <= m2[sdd_pkg::MONTH_W-1:0];
        second_year  <= y2[sdd_pkg::YEAR_W-1:0];
        include_end  <= count_end[0];
        start        <= 1'b1;
        while (busy)
            @(negedge clk);
        @(posedge clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 40);
            // Now and then a long run of back-to-back beats with no pause at all.
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 20)
                                                     : $urandom_range(0, 4);
            @(negedge clk);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Mostly days that exist in every month, sometimes the days that only some have.
    function automatic int any_day();
        return ($urandom_range(0, 4) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28);
    endfunction

    initial begin
        int kind;
        int reach;
        int d1, m1, y1, d2, m2, y2;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Equal dates, with and without the end day counted.
        present_dates(15, 6, 2024, 15, 6, 2024, 0);
        present_dates(15, 6, 2024, 15, 6, 2024, 1);
        // A whole leap year forward, then backward with the end day counted.
        present_dates(1, 1, 2024, 31, 12, 2024, 0);
        present_dates(31, 12, 2024, 1, 1, 2024, 1);
        // Century rules: 1900 and 2100 are common years, 2000 and 2400 are leap years.
        present_dates(28, 2, 1900, 1, 3, 1900, 0);
        present_dates(28, 2, 2000, 1, 3, 2000, 0);
        present_dates(29, 2, 2400, 1, 3, 2400, 0);
        present_dates(29, 2, 1900, 1, 3, 1900, 0);
        present_dates(1, 3, 2100, 29, 2, 2100, 1);
        // Illegal months and days in either date.
        present_dates(30, 2, 2024, 1, 3, 2024, 0);
        present_dates(10, 0, 2024, 10, 5, 2024, 0);
        present_dates(10, 5, 2024, 10, 13, 2024, 1);
        present_dates(31, 15, 2024, 1, 1, 2024, 0);
        present_dates(0, 7, 2024, 1, 7, 2024, 0);
        present_dates(1, 4, 2024, 31, 4, 2024, 0);
        // Across a year boundary.
        present_dates(31, 12, 1999, 1, 1, 2000, 1);
        // Year zero counts as a leap year.
        present_dates(29, 2, 0, 1, 3, 0, 0);
        present_dates(1, 1, 1, 31, 12, 0, 0);
        // Edges of the stated year range and of the year field.
        present_dates(1, 1, 1, 31, 1, 1, 1);
        present_dates(31, 12, 9999, 1, 1, 9999, 0);
        present_dates(31, 12, YEAR_TOP, 1, 1, YEAR_TOP, 0);
        present_dates(31, 12, YEAR_TOP, 31, 12, YEAR_TOP, 1);
        // Exactly the largest magnitude apart; counting the end day must saturate.
        present_dates(1, 1, 0, 12, 8, 11483, 1);

        // Random beats. Most pairs are legal dates a year or so apart with random
        // content; some lie further apart, some are equal, and the rest carry raw
        // day and month values that are often illegal.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            kind  = $urandom_range(0, 99);
            reach = (kind >= 60 && kind < 75) ? 8 : 1;
            y1 = $urandom_range(0, YEAR_TOP);
            m1 = $urandom_range(1, 12);
            d1 = any_day();
            y2 = y1 + $urandom_range(0, 2 * reach) - reach;
            if (y2 < 0)
                y2 = 0;
            if (y2 > YEAR_TOP)
                y2 = YEAR_TOP;
            m2 = $urandom_range(1, 12);
            d2 = any_day();
            if (kind >= 75 && kind < 85) begin
                d2 = d1;
                m2 = m1;
                y2 = y1;
            end else if (kind >= 85) begin
                if ($urandom_range(0, 1) == 0) begin
                    d1 = $urandom_range(0, 31);
                    m1 = $urandom_range(0, 15);
                end else begin
                    d2 = $urandom_range(0, 31);
                    m2 = $urandom_range(0, 15);
                end
            end
            present_dates(d1, m1, y1, d2, m2, y2, $urandom_range(0, 1));
        end

        // The monitor records the last beat at the edge that took it, so look one
        // half cycle later, then allow a short drain for any stray result.
        @(negedge clk);
        start <= 1'b0;
        wait (results_pending == 0);
        repeat (20) @(posedge clk);

        if (mismatch_total == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
